>>> src/region_bump_frame_allocator_core_defines.svh
// assertion macros for the region bump frame allocator
`ifndef REGION_BUMP_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define REGION_BUMP_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RBFA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RBFA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rbfa_pkg.sv
// shared types, codes and control structs of the region bump frame allocator
`default_nettype none

package rbfa_pkg;

    localparam int FRAME_W   = 40;
    localparam int TYPE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int RSV_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [TYPE_W-1:0] ENTRY_AVAILABLE = 8'd1;

    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_AVAIL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED     = 2'd2;

    typedef struct packed {
        logic               op;
        logic [TYPE_W-1:0]  entry_type;
        logic [FRAME_W-1:0] region_start_frame;
        logic [FRAME_W-1:0] region_frames;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_number;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic add;
        logic rd_first;
        logic first;
        logic load;
        logic skip;
        logic grant;
        logic set_oom;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_alloc;
        logic started;
        logic count_zero;
        logic left_zero;
        logic more_regions;
        logic kern_hit;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> src/rbfa_ctrl.sv
// controller state machine of the region bump frame allocator
`default_nettype none

`include "region_bump_frame_allocator_core_defines.svh"

module rbfa_ctrl
    import rbfa_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIRST,
        S_EVAL,
        S_LOAD,
        S_KCHECK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!sts.op_alloc) begin
                    cmd.add    = 1'b1;
                    state_next = S_EMIT;
                end else if (sts.started) begin
                    state_next = S_EVAL;
                end else if (sts.count_zero) begin
                    cmd.set_oom = 1'b1;
                    state_next  = S_EMIT;
                end else begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_FIRST;
                end
            end
            S_FIRST: begin
                cmd.first  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!sts.left_zero) begin
                    state_next = S_KCHECK;
                end else if (sts.more_regions) begin
                    state_next = S_LOAD;
                end else begin
                    cmd.set_oom = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = S_EVAL;
            end
            S_KCHECK: begin
                if (sts.kern_hit) begin
                    cmd.skip   = 1'b1;
                    state_next = S_EVAL;
                end else begin
                    cmd.grant  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RBFA_ASSERT_IMP(a_first_once, aclk, aresetn, state_reg == S_FIRST, !sts.started, "first region load after allocation already started")
    `RBFA_ASSERT_IMP(a_grant_has_frames, aclk, aresetn, cmd.grant, !sts.left_zero, "frame granted from an exhausted region")
    `RBFA_ASSERT_NXT(a_capture_dispatch, aclk, aresetn, cmd.capture, state_reg == S_DISPATCH, "captured item not dispatched")

endmodule

`default_nettype wire

>>> src/rbfa_datapath.sv
// region table, cursor and result registers of the region bump frame allocator
`default_nettype none

`include "region_bump_frame_allocator_core_defines.svh"

module rbfa_datapath
    import rbfa_pkg::*;
#(
    parameter int REGION_SLOTS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire in_item_t             s_data,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FRAME_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(REGION_SLOTS + 1);
    localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

    logic [FRAME_W-1:0] base_mem [REGION_SLOTS];
    logic [FRAME_W-1:0] len_mem  [REGION_SLOTS];

    logic [FRAME_W-1:0] kfirst_reg;
    logic [FRAME_W-1:0] klast_reg;
    logic [RSV_W-1:0]   reserved_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   next_reg;
    logic [FRAME_W-1:0] cursor_reg;
    logic [FRAME_W-1:0] left_reg;
    logic               started_reg;

    in_item_t           item_reg;
    logic [FRAME_W-1:0] rd_base_reg;
    logic [FRAME_W-1:0] rd_len_reg;
    logic               kern_hit_reg;
    logic [FRAME_W:0]   span_reg;
    logic [FRAME_W-1:0] res_frame_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic               table_full;
    logic               add_ok;
    logic [IDX_W-1:0]   rd_addr;
    logic [FRAME_W-1:0] rsv_ext;
    logic [FRAME_W-1:0] first_cursor;
    logic [FRAME_W-1:0] first_left;
    logic [FRAME_W:0]   span_calc;
    logic [FRAME_W-1:0] skip_n;

    assign table_full   = (count_reg == CNT_W'(REGION_SLOTS));
    assign add_ok       = (item_reg.entry_type == ENTRY_AVAILABLE) && !table_full;
    assign rd_addr      = cmd.rd_first ? '0 : next_reg[IDX_W-1:0];
    assign rsv_ext      = FRAME_W'(reserved_reg);
    assign first_cursor = rd_base_reg + rsv_ext;
    assign first_left   = (rsv_ext > rd_len_reg) ? '0 : (rd_len_reg - rsv_ext);
    assign span_calc    = {1'b0, klast_reg} - {1'b0, cursor_reg} + (FRAME_W+1)'(1);
    assign skip_n       = (span_reg >= {1'b0, left_reg}) ? left_reg : span_reg[FRAME_W-1:0];

    assign sts.op_alloc     = (item_reg.op == OP_ALLOC);
    assign sts.started      = started_reg;
    assign sts.count_zero   = (count_reg == '0);
    assign sts.left_zero    = (left_reg == '0);
    assign sts.more_regions = (next_reg < count_reg);
    assign sts.kern_hit     = kern_hit_reg;
    assign sts.out_free     = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kfirst_reg   <= '0;
            klast_reg    <= '0;
            reserved_reg <= RSV_W'(1);
            count_reg    <= '0;
            next_reg     <= '0;
            cursor_reg   <= '0;
            left_reg     <= '0;
            started_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_KERNEL_FIRST: kfirst_reg   <= cfg_data;
                    CFG_KERNEL_LAST:  klast_reg    <= cfg_data;
                    CFG_RESERVED:     reserved_reg <= cfg_data[RSV_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.add && add_ok) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.first) begin
                started_reg <= 1'b1;
                next_reg    <= CNT_W'(1);
                cursor_reg  <= first_cursor;
                left_reg    <= first_left;
            end
            if (cmd.load) begin
                cursor_reg <= rd_base_reg;
                left_reg   <= rd_len_reg;
                next_reg   <= next_reg + CNT_W'(1);
            end
            if (cmd.skip) begin
                cursor_reg <= cursor_reg + skip_n;
                left_reg   <= left_reg - skip_n;
            end
            if (cmd.grant) begin
                cursor_reg <= cursor_reg + FRAME_W'(1);
                left_reg   <= left_reg - FRAME_W'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // region table
    always_ff @(posedge aclk) begin
        if (cmd.add && add_ok) begin
            base_mem[count_reg[IDX_W-1:0]] <= item_reg.region_start_frame;
            len_mem[count_reg[IDX_W-1:0]]  <= item_reg.region_frames;
        end
        rd_base_reg <= base_mem[rd_addr];
        rd_len_reg  <= len_mem[rd_addr];
    end

    // item, kernel check and result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        kern_hit_reg <= (kfirst_reg <= cursor_reg) && (cursor_reg <= klast_reg);
        span_reg     <= span_calc;
        if (cmd.add) begin
            res_frame_reg <= '0;
            if (item_reg.entry_type != ENTRY_AVAILABLE) begin
                res_status_reg <= ST_NOT_AVAIL;
            end else if (table_full) begin
                res_status_reg <= ST_FULL;
            end else begin
                res_status_reg <= ST_STORED;
            end
        end
        if (cmd.set_oom) begin
            res_frame_reg  <= '0;
            res_status_reg <= ST_OOM;
        end
        if (cmd.grant) begin
            res_frame_reg  <= cursor_reg;
            res_status_reg <= ST_GRANTED;
        end
        if (cmd.emit) begin
            m_data_reg.frame_number <= res_frame_reg;
            m_data_reg.status       <= res_status_reg;
        end
    end

    `RBFA_ASSERT_IMP(a_next_within_count, aclk, aresetn, 1'b1, next_reg <= count_reg, "region walk passed the stored region count")
    `RBFA_ASSERT_NXT(a_emit_sets_valid, aclk, aresetn, cmd.emit, m_valid_reg, "emitted result not presented")
    `RBFA_ASSERT_IMP(a_emit_when_free, aclk, aresetn, cmd.emit, !m_valid_reg || m_ready, "result overwritten before it was taken")

endmodule

`default_nettype wire

>>> src/region_bump_frame_allocator_core.sv
// Region bump frame allocator: stores up to REGION_SLOTS available memory regions and
// hands out page frames from them in order, skipping the reserved frames at the start
// of region 0 and every frame in the inclusive kernel range. One item is worked on at a
// time. An add-region item is captured, dispatched and emitted. A granted allocation
// runs the controller's evaluate/check loop: region 0 is loaded on the first one, the
// next region is read from the one-read region table on each region change, and the
// cursor jumps over the kernel range when it lands in it. Out of memory comes back
// from dispatch on an empty table and otherwise once the last region is used up.
// A new item is accepted while a finished result still waits in the output register.
// cfg_ready is always high.
`default_nettype none

module region_bump_frame_allocator_core
    import rbfa_pkg::*;
#(
    parameter int REGION_SLOTS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FRAME_W-1:0]   cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    rbfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbfa_datapath #(
        .REGION_SLOTS (REGION_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
